[rtl/tfr_pkg.sv]
// shared types, constants and functions of the throttle frame receiver
package tfr_pkg;

    localparam int FRAME_LENGTH = 20;
    localparam int IDX_W        = $clog2(FRAME_LENGTH);

    localparam logic [7:0] SOF_BYTE    = 8'h01;
    localparam logic [7:0] LEN_BYTE    = FRAME_LENGTH[7:0];
    localparam logic [7:0] TYPE_BYTE   = 8'h01;
    localparam logic [7:0] CRC_POLY    = 8'h01;
    localparam int         LIGHT_BIT   = 5;

    localparam logic [IDX_W-1:0] IDX_SOF      = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_LEN      = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_TYPE     = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_LIGHT    = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_LEVER_HI = IDX_W'(16);
    localparam logic [IDX_W-1:0] IDX_LEVER_LO = IDX_W'(17);

    // floor(diff * 32768 / 600) == (diff * THR_RECIP) >> THR_SHIFT for 10-bit diff
    localparam logic [22:0] THR_RECIP = 23'd7158279;
    localparam int          THR_SHIFT = 17;

    localparam logic [15:0] TIMEOUT_TICKS_DEFAULT = 16'd1100;
    localparam logic [9:0]  LEVER_MIN_RESET       = 10'd400;

    localparam int PADDR_W = 3;

    typedef enum logic [0:0] {
        REG_TIMEOUT   = 1'b0,
        REG_LEVER_MIN = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        EVT_FRAME   = 1'b0,
        EVT_TIMEOUT = 1'b1
    } t_event;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [9:0]  lever_min;
    } t_cfg;

    typedef struct packed {
        logic        event_res;
        logic        crc_ok;
        logic        light_enable;
        logic [9:0]  lever_value;
        logic [15:0] throttle_q15;
        logic        brakes_released;
        logic        drive_request;
    } t_result;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/tfr_in_if.sv]
// input channel: received bytes and millisecond ticks
interface tfr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;
    logic       pad_released;

    modport source (output valid, output kind, output rx_byte, output pad_released,
                    input ready);
    modport sink   (input valid, input kind, input rx_byte, input pad_released,
                    output ready);
endinterface

[rtl/tfr_out_if.sv]
// output channel: frame and timeout results
interface tfr_out_if;
    logic        valid;
    logic        ready;
    logic        event_res;
    logic        crc_ok;
    logic        light_enable;
    logic [9:0]  lever_value;
    logic [15:0] throttle_q15;
    logic        brakes_released;
    logic        drive_request;

    modport source (output valid, output event_res, output crc_ok, output light_enable,
                    output lever_value, output throttle_q15, output brakes_released,
                    output drive_request, input ready);
    modport sink   (input valid, input event_res, input crc_ok, input light_enable,
                    input lever_value, input throttle_q15, input brakes_released,
                    input drive_request, output ready);
endinterface

[rtl/throttle_frame_receiver_core.sv]
// top level of the throttle frame receiver
// Takes one byte or tick transfer per clock cycle whenever the result register is empty or
// being drained; a frame-end or timeout result shows on the output in the cycle after the
// transfer that causes it. The crc byte update, the header check, the brake debounce and
// the throttle scaling (one 10 by 23 bit constant multiply) sit combinationally ahead of
// the result register. Registers: 0x0 timeout_ticks, 0x4 lever_min.
module throttle_frame_receiver_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tfr_in_if.sink                      i_in,
    tfr_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    tfr_pkg::t_cfg    w_cfg;
    tfr_pkg::t_result w_res;
    tfr_pkg::t_result w_out_res;
    logic             w_res_valid;
    logic             w_free;
    logic             w_accept;

    assign i_in.ready = w_free;
    assign w_accept   = i_in.valid && w_free;

    tfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tfr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_kind         (i_in.kind),
        .i_rx_byte      (i_in.rx_byte),
        .i_pad_released (i_in.pad_released),
        .i_cfg          (w_cfg),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    tfr_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_valid),
        .i_res       (w_res),
        .i_out_ready (o_out.ready),
        .o_free      (w_free),
        .o_valid     (o_out.valid),
        .o_res       (w_out_res)
    );

    assign o_out.event_res       = w_out_res.event_res;
    assign o_out.crc_ok          = w_out_res.crc_ok;
    assign o_out.light_enable    = w_out_res.light_enable;
    assign o_out.lever_value     = w_out_res.lever_value;
    assign o_out.throttle_q15    = w_out_res.throttle_q15;
    assign o_out.brakes_released = w_out_res.brakes_released;
    assign o_out.drive_request   = w_out_res.drive_request;

    a_timeout_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.event_res |->
            !o_out.crc_ok && o_out.throttle_q15 == 16'd0 && !o_out.drive_request)
        else $error("timeout result carries frame data");

    a_bad_crc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.crc_ok |->
            o_out.lever_value == 10'd0 && o_out.throttle_q15 == 16'd0 && !o_out.light_enable)
        else $error("result without good crc carries frame data");

    a_drive_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.drive_request |-> o_out.brakes_released && o_out.crc_ok)
        else $error("drive request with brakes pulled or bad crc");

    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while result is stalled");

endmodule

[rtl/tfr_cfg.sv]
// apb configuration registers
module tfr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output tfr_pkg::t_cfg               o_cfg
);

    tfr_pkg::t_cfg    r_cfg;
    tfr_pkg::t_cfg    n_cfg;
    tfr_pkg::t_cfg_reg w_sel;
    logic             w_wr;

    assign w_sel  = tfr_pkg::t_cfg_reg'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_sel)
                tfr_pkg::REG_TIMEOUT:   n_cfg.timeout_ticks = pwdata[15:0];
                tfr_pkg::REG_LEVER_MIN: n_cfg.lever_min     = pwdata[9:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            tfr_pkg::REG_TIMEOUT:   prdata = {16'd0, r_cfg.timeout_ticks};
            tfr_pkg::REG_LEVER_MIN: prdata = {22'd0, r_cfg.lever_min};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= tfr_pkg::TIMEOUT_TICKS_DEFAULT;
            r_cfg.lever_min     <= tfr_pkg::LEVER_MIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/tfr_parser.sv]
// frame parser, crc, brake debounce, timeout counter and result build
module tfr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_kind,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_pad_released,
    input  tfr_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output tfr_pkg::t_result o_res
);

    logic [tfr_pkg::IDX_W-1:0] r_idx,  n_idx;
    logic [7:0]                r_crc,  n_crc;
    logic                      r_light, n_light;
    logic [1:0]                r_lever_hi, n_lever_hi;
    logic [7:0]                r_lever_lo, n_lever_lo;
    logic                      r_last_pad, n_last_pad;
    logic                      r_brake, n_brake;
    logic [15:0]               r_idle, n_idle;

    logic [16:0]               w_idle_inc;
    logic [tfr_pkg::IDX_W:0]   w_idx_inc;
    logic                      w_bad;
    logic [9:0]                w_lever;
    logic [9:0]                w_diff;
    logic [32:0]               w_prod;
    logic [15:0]               w_thr;

    assign w_idle_inc = {1'b0, r_idle} + 17'd1;
    assign w_idx_inc  = {1'b0, r_idx} + 1'b1;
    assign w_bad      = ({1'b0, r_idx} >= (tfr_pkg::IDX_W+1)'(tfr_pkg::FRAME_LENGTH))
                     || (r_idx == tfr_pkg::IDX_SOF  && i_rx_byte != tfr_pkg::SOF_BYTE)
                     || (r_idx == tfr_pkg::IDX_LEN  && i_rx_byte != tfr_pkg::LEN_BYTE)
                     || (r_idx == tfr_pkg::IDX_TYPE && i_rx_byte != tfr_pkg::TYPE_BYTE);

    // lever bytes taken by position, including the byte in flight
    assign w_lever = {(r_idx == tfr_pkg::IDX_LEVER_HI) ? i_rx_byte[1:0] : r_lever_hi,
                      (r_idx == tfr_pkg::IDX_LEVER_LO) ? i_rx_byte : r_lever_lo};
    assign w_diff  = w_lever - i_cfg.lever_min;
    assign w_prod  = 33'(w_diff) * 33'(tfr_pkg::THR_RECIP);
    assign w_thr   = (w_lever >= i_cfg.lever_min) ? w_prod[tfr_pkg::THR_SHIFT +: 16] : 16'd0;

    always_comb begin
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_light     = r_light;
        n_lever_hi  = r_lever_hi;
        n_lever_lo  = r_lever_lo;
        n_last_pad  = r_last_pad;
        n_brake     = r_brake;
        n_idle      = r_idle;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (i_kind) begin
                if (w_idle_inc > {1'b0, i_cfg.timeout_ticks}) begin
                    n_idle                = 16'd0;
                    n_idx                 = '0;
                    n_crc                 = 8'd0;
                    o_res_valid           = 1'b1;
                    o_res.event_res       = tfr_pkg::EVT_TIMEOUT;
                    o_res.brakes_released = r_brake;
                end else begin
                    n_idle = w_idle_inc[15:0];
                end
            end else if (w_bad) begin
                n_idx = '0;
                n_crc = 8'd0;
            end else begin
                if (r_idx == tfr_pkg::IDX_LIGHT)    n_light    = i_rx_byte[tfr_pkg::LIGHT_BIT];
                if (r_idx == tfr_pkg::IDX_LEVER_HI) n_lever_hi = i_rx_byte[1:0];
                if (r_idx == tfr_pkg::IDX_LEVER_LO) n_lever_lo = i_rx_byte;
                if (w_idx_inc < (tfr_pkg::IDX_W+1)'(tfr_pkg::FRAME_LENGTH)) begin
                    n_crc = tfr_pkg::crc8_update((r_idx == tfr_pkg::IDX_SOF) ? 8'd0 : r_crc,
                                                 i_rx_byte);
                    n_idx = w_idx_inc[tfr_pkg::IDX_W-1:0];
                end else begin
                    if (i_pad_released == r_last_pad) n_brake = i_pad_released;
                    n_last_pad            = i_pad_released;
                    o_res_valid           = 1'b1;
                    o_res.event_res       = tfr_pkg::EVT_FRAME;
                    o_res.brakes_released = n_brake;
                    if (r_crc == i_rx_byte) begin
                        n_idle              = 16'd0;
                        o_res.crc_ok        = 1'b1;
                        o_res.light_enable  = n_light;
                        o_res.lever_value   = w_lever;
                        o_res.throttle_q15  = w_thr;
                        o_res.drive_request = n_brake && (w_lever > i_cfg.lever_min);
                    end
                    n_idx = '0;
                    n_crc = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_crc      <= 8'd0;
            r_light    <= 1'b0;
            r_lever_hi <= 2'd0;
            r_lever_lo <= 8'd0;
            r_last_pad <= 1'b0;
            r_brake    <= 1'b0;
            r_idle     <= 16'd0;
        end else begin
            r_idx      <= n_idx;
            r_crc      <= n_crc;
            r_light    <= n_light;
            r_lever_hi <= n_lever_hi;
            r_lever_lo <= n_lever_lo;
            r_last_pad <= n_last_pad;
            r_brake    <= n_brake;
            r_idle     <= n_idle;
        end
    end

endmodule

[rtl/tfr_outreg.sv]
// result register between the parser and the output channel
module tfr_outreg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tfr_pkg::t_result i_res,
    input  logic             i_out_ready,
    output logic             o_free,
    output logic             o_valid,
    output tfr_pkg::t_result o_res
);

    logic             r_valid, n_valid;
    tfr_pkg::t_result r_res;

    assign o_free  = !r_valid || i_out_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
